// ===== rtl/core/epd_pkg.sv =====
`default_nettype none

package epd_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Position inside the packet body
  localparam logic [2:0] POS_REG  = 3'd0;
  localparam logic [2:0] POS_DATA = 3'd1;
  localparam logic [2:0] POS_SUM  = 3'd5;
  localparam logic [2:0] POS_DONE = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEAD   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE = 2'd1;
  localparam logic [1:0] CFG_XOR    = 2'd2;

  localparam logic [7:0] HEAD_RESET   = 8'd126;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;
  localparam logic [7:0] XOR_RESET    = 8'd32;

  typedef struct packed {
    logic [7:0]  reg_addr;
    logic [31:0] data_word;
    logic        packet_ok;
  } res_t;

  typedef struct packed {
    logic head_valid;
    logic tail_valid;
  } buf_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/epd_out_buf.sv =====
`default_nettype none

module epd_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire epd_pkg::res_t       push_data,
  output logic                     space,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output epd_pkg::res_t            out_data,
  output epd_pkg::buf_status_t     status
);
  import epd_pkg::*;

  res_t head_r, head_nxt;
  res_t tail_r, tail_nxt;
  logic head_valid_r, head_valid_nxt;
  logic tail_valid_r, tail_valid_nxt;
  logic pop;

  assign pop = head_valid_r & out_ready;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    head_valid_nxt = head_valid_r;
    tail_valid_nxt = tail_valid_r;
    // advance the tail word into the head slot on a pop
    if (pop) begin
      if (tail_valid_r) begin
        head_nxt       = tail_r;
        tail_valid_nxt = 1'b0;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!head_valid_nxt) begin
        head_nxt       = push_data;
        head_valid_nxt = 1'b1;
      end else begin
        tail_nxt       = push_data;
        tail_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      tail_valid_r <= tail_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign space             = ~tail_valid_r;
  assign out_valid         = head_valid_r;
  assign out_data          = head_r;
  assign status.head_valid = head_valid_r;
  assign status.tail_valid = tail_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/escaped_packet_deframer.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_byte[7:0]
// out_      output     out_valid / out_ready  out_reg_addr[7:0], out_data_word[31:0],
//                                             out_packet_ok
// cfg_      input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// One byte per cycle while in_ready is high: each accepted word updates the
// parser registers in the same cycle, and a finished packet result lands in a
// two-word output buffer of registered slots; the head slot drives out_valid.
// in_ready drops only while both output buffer slots hold results.
// cfg_ready is always high. Reset is synchronous, active low, and restores the
// register defaults and the hunting state.

module escaped_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_reg_addr,
  output logic [31:0]      out_data_word,
  output logic             out_packet_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import epd_pkg::*;

  // configuration registers
  logic [7:0] head_value_r;
  logic [7:0] escape_value_r;
  logic [7:0] escape_xor_r;

  // parser state
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [2:0]  field_pos_r, field_pos_nxt;
  logic        escape_pending_r, escape_pending_nxt;
  logic [7:0]  sum_acc_r, sum_acc_nxt;
  logic [31:0] word_acc_r, word_acc_nxt;
  logic [7:0]  reg_hold_r, reg_hold_nxt;
  logic        sum_match_r, sum_match_nxt;

  logic        in_accept;
  logic        emit;
  logic        ok;
  res_t        res;
  res_t        out_res;
  logic        buf_space;
  buf_status_t buf_st;

  assign cfg_ready = 1'b1;
  assign in_ready  = buf_space;
  assign in_accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_value_r   <= HEAD_RESET;
      escape_value_r <= ESCAPE_RESET;
      escape_xor_r   <= XOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to indexes past the register list
      unique case (cfg_index)
        CFG_HEAD:   head_value_r   <= cfg_data;
        CFG_ESCAPE: escape_value_r <= cfg_data;
        CFG_XOR:    escape_xor_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    bytes_left_nxt     = bytes_left_r;
    field_pos_nxt      = field_pos_r;
    escape_pending_nxt = escape_pending_r;
    sum_acc_nxt        = sum_acc_r;
    word_acc_nxt       = word_acc_r;
    reg_hold_nxt       = reg_hold_r;
    sum_match_nxt      = sum_match_r;
    emit               = 1'b0;
    ok                 = 1'b0;
    res                = '0;

    if (in_accept) begin
      unique case (phase_r)
        PH_LEN: begin
          // start a fresh packet; a zero length reports an error at once
          field_pos_nxt      = POS_REG;
          escape_pending_nxt = 1'b0;
          sum_acc_nxt        = '0;
          word_acc_nxt       = '0;
          reg_hold_nxt       = '0;
          sum_match_nxt      = 1'b0;
          bytes_left_nxt     = in_byte;
          if (in_byte == 8'd0) begin
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (field_pos_r == POS_REG) begin
            reg_hold_nxt  = in_byte;
            sum_acc_nxt   = in_byte;
            field_pos_nxt = POS_DATA;
          end else if (field_pos_r < POS_SUM) begin
            // escapes count toward the checksum too
            sum_acc_nxt = sum_acc_r + in_byte;
            if (escape_pending_r) begin
              word_acc_nxt       = {word_acc_r[23:0], in_byte ^ escape_xor_r};
              escape_pending_nxt = 1'b0;
              field_pos_nxt      = field_pos_r + 3'd1;
            end else if (in_byte == escape_value_r) begin
              escape_pending_nxt = 1'b1;
            end else begin
              word_acc_nxt  = {word_acc_r[23:0], in_byte};
              field_pos_nxt = field_pos_r + 3'd1;
            end
          end else if (field_pos_r == POS_SUM) begin
            sum_match_nxt = (sum_acc_r == in_byte);
            field_pos_nxt = POS_DONE;
          end
          // bytes past the checksum only count down

          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_nxt == 8'd0) begin
            emit = 1'b1;
            ok   = (field_pos_nxt == POS_DONE) && sum_match_nxt;
            if (ok) begin
              res.reg_addr  = reg_hold_nxt;
              res.data_word = word_acc_nxt;
            end
            phase_nxt          = PH_HUNT;
            field_pos_nxt      = POS_REG;
            escape_pending_nxt = 1'b0;
            sum_acc_nxt        = '0;
            word_acc_nxt       = '0;
            reg_hold_nxt       = '0;
            sum_match_nxt      = 1'b0;
          end
        end
        default: begin
          // hunting, and the unused phase code behaves the same
          phase_nxt = (in_byte == head_value_r) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
    res.packet_ok = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HUNT;
      bytes_left_r     <= '0;
      field_pos_r      <= POS_REG;
      escape_pending_r <= 1'b0;
      sum_acc_r        <= '0;
      word_acc_r       <= '0;
      reg_hold_r       <= '0;
      sum_match_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      bytes_left_r     <= bytes_left_nxt;
      field_pos_r      <= field_pos_nxt;
      escape_pending_r <= escape_pending_nxt;
      sum_acc_r        <= sum_acc_nxt;
      word_acc_r       <= word_acc_nxt;
      reg_hold_r       <= reg_hold_nxt;
      sum_match_r      <= sum_match_nxt;
    end
  end

  // hold finished results until the sink takes them
  epd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .space     (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res),
    .status    (buf_st)
  );

  assign out_reg_addr  = out_res.reg_addr;
  assign out_data_word = out_res.data_word;
  assign out_packet_ok = out_res.packet_ok;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_ok |-> out_reg_addr == 8'd0 && out_data_word == 32'd0)
    else $error("error result carries nonzero fields");

  a_buf_order: assert property (@(posedge clk) disable iff (!rst_n)
    buf_st.tail_valid |-> buf_st.head_valid)
    else $error("output buffer tail filled with empty head");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && phase_r == PH_LEN && in_byte == 8'd0 |=> out_valid)
    else $error("zero length produced no result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_pos_r <= POS_DONE)
    else $error("field position out of range");

endmodule

`default_nettype wire

// ===== tb/escaped_packet_deframer_checker.sv =====
`timescale 1ns / 1ps

module escaped_packet_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_reg_addr,
  input  logic [31:0] out_data_word,
  input  logic        out_packet_ok,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          pending_results
);
  import epd_pkg::*;

  logic [7:0] hdr_val, esc_byte, esc_mask;

  logic [1:0]  phase_q;
  logic [7:0]  left_q;
  logic [2:0]  pos_q;
  logic        esc_pend_q;
  logic [7:0]  sum_q;
  logic [31:0] word_q;
  logic [7:0]  reg_q;
  logic        match_q;

  res_t expected_packets[$];
  int   fails = 0;

  task automatic clear_packet_state();
    left_q     = 8'd0;
    pos_q      = POS_REG;
    esc_pend_q = 1'b0;
    sum_q      = 8'd0;
    word_q     = 32'd0;
    reg_q      = 8'd0;
    match_q    = 1'b0;
  endtask

  // Advance the parser by one received word; queue a result when a packet closes.
  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    if (phase_q == PH_LEN) begin
      clear_packet_state();
      if (b == 8'd0) begin
        phase_q = PH_HUNT;
        r = '0;
        expected_packets.insert(expected_packets.size(), r);
      end else begin
        left_q  = b;
        phase_q = PH_BODY;
      end
    end else if (phase_q != PH_BODY) begin
      phase_q = (b == hdr_val) ? PH_LEN : PH_HUNT;
    end else begin
      if (pos_q == POS_REG) begin
        reg_q = b;
        sum_q = b;
        pos_q = POS_DATA;
      end else if (pos_q < POS_SUM) begin
        sum_q = sum_q + b;
        if (esc_pend_q) begin
          word_q     = {word_q[23:0], b ^ esc_mask};
          esc_pend_q = 1'b0;
          pos_q      = pos_q + 3'd1;
        end else if (b == esc_byte) begin
          esc_pend_q = 1'b1;
        end else begin
          word_q = {word_q[23:0], b};
          pos_q  = pos_q + 3'd1;
        end
      end else if (pos_q == POS_SUM) begin
        match_q = (sum_q == b);
        pos_q   = POS_DONE;
      end
      left_q = left_q - 8'd1;
      if (left_q == 8'd0) begin
        r.packet_ok = (pos_q == POS_DONE) && match_q;
        r.reg_addr  = r.packet_ok ? reg_q : 8'd0;
        r.data_word = r.packet_ok ? word_q : 32'd0;
        expected_packets.insert(expected_packets.size(), r);
        phase_q = PH_HUNT;
        clear_packet_state();
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    fails++;
    if (fails <= 10)
      $display("[%0t] checker: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      hdr_val   = HEAD_RESET;
      esc_byte  = ESCAPE_RESET;
      esc_mask  = XOR_RESET;
      phase_q   = PH_HUNT;
      clear_packet_state();
      expected_packets.delete();
    end else begin
      // compare before predicting: a result never leaves in the cycle its word arrives
      if (out_valid && out_ready) begin
        if (expected_packets.size() == 0) begin
          flag_mismatch($sformatf("unexpected result reg %02h data %08h ok %0b",
                                  out_reg_addr, out_data_word, out_packet_ok));
        end else begin
          want = expected_packets.pop_front();
          if (out_reg_addr !== want.reg_addr || out_data_word !== want.data_word ||
              out_packet_ok !== want.packet_ok)
            flag_mismatch($sformatf(
              "expected reg %02h data %08h ok %0b, got reg %02h data %08h ok %0b",
              want.reg_addr, want.data_word, want.packet_ok,
              out_reg_addr, out_data_word, out_packet_ok));
        end
      end
      // a word taken at the same edge as a register write still sees the old value
      if (in_valid && in_ready)
        deframe_byte(in_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEAD:   hdr_val  = cfg_data;
          CFG_ESCAPE: esc_byte = cfg_data;
          CFG_XOR:    esc_mask = cfg_data;
          default:    ;
        endcase
      end
    end
    mismatch_count  <= fails;
    pending_results <= expected_packets.size();
  end

endmodule

// ===== tb/tb_escaped_packet_deframer.sv =====
`timescale 1ns / 1ps

module tb_escaped_packet_deframer;
  import epd_pkg::*;

  // Index past the end of the register map; the block must drop writes to it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Packet shapes the stimulus can build
  localparam int PK_GOOD    = 0;
  localparam int PK_EMPTY   = 1;
  localparam int PK_SHORT   = 2;
  localparam int PK_BAD_SUM = 3;
  localparam int PK_PADDED  = 4;
  localparam int PK_MAXLEN  = 5;

  // Receiver stall patterns
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_PULSE = 3;

  localparam int WORDS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 8;

  // register word, up to eight data words with escapes, checksum
  localparam int BODY_MAX = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [7:0]  in_byte;
  logic        out_valid, out_ready;
  logic [7:0]  out_reg_addr;
  logic [31:0] out_data_word;
  logic        out_packet_ok;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatch_count;
  int pending_results;

  // Current register settings, kept here so packets are framed and escaped to match.
  logic [7:0] head_cur, esc_cur, mask_cur;

  int words_sent = 0;
  int burst_left = 0;
  int gap_max    = 0;
  int hold_len   = 0;

  always #5 clk = ~clk;

  escaped_packet_deframer u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_reg_addr (out_reg_addr),
    .out_data_word(out_data_word),
    .out_packet_ok(out_packet_ok),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  escaped_packet_deframer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_addr   (out_reg_addr),
    .out_data_word  (out_data_word),
    .out_packet_ok  (out_packet_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // Offer one word and hold it until the block takes it. Between bursts, drop
  // valid for a random gap; a gap of zero keeps valid high across the burst edge.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted result has left the block,
  // then idle while the output buffer settles.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // Present one register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HEAD:   head_cur = val;
      CFG_ESCAPE: esc_cur  = val;
      CFG_XOR:    mask_cur = val;
      default:    ;
    endcase
  endtask

  task automatic configure(input logic [7:0] head, input logic [7:0] esc,
                           input logic [7:0] mask);
    drain();
    write_reg(CFG_HEAD, head);
    write_reg(CFG_ESCAPE, esc);
    write_reg(CFG_XOR, mask);
    cfg_valid <= 1'b0;
  endtask

  // Bias toward the values the parser treats specially.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return head_cur;
      1:       return esc_cur;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Frame one packet: head, length, register word, escaped data, checksum.
  // The shape decides how the length and checksum are bent.
  task automatic send_packet(input int kind, input logic [7:0] reg_b,
                             input logic [31:0] data, input int esc_pct);
    logic [7:0] body[BODY_MAX];
    int         nbody;
    logic [7:0] sum;
    logic [7:0] d;
    int         len;
    push_byte(head_cur);
    if (kind == PK_EMPTY) begin
      push_byte(8'd0);
      return;
    end
    nbody = 0;
    body[nbody] = reg_b;
    nbody++;
    sum = reg_b;
    for (int i = 3; i >= 0; i--) begin
      d = data[8*i +: 8];
      // a data word equal to the escape value must go out escaped
      if (d == esc_cur || $urandom_range(0, 99) < esc_pct) begin
        body[nbody] = esc_cur;
        nbody++;
        body[nbody] = d ^ mask_cur;
        nbody++;
        sum = sum + esc_cur + (d ^ mask_cur);
      end else begin
        body[nbody] = d;
        nbody++;
        sum = sum + d;
      end
    end
    body[nbody] = (kind == PK_BAD_SUM) ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
    nbody++;
    len = nbody;
    case (kind)
      PK_SHORT:  len = $urandom_range(1, nbody - 1);
      PK_PADDED: len = nbody + $urandom_range(1, 8);
      PK_MAXLEN: len = 255;
      default:   ;
    endcase
    push_byte(len[7:0]);
    for (int i = 0; i < len; i++)
      push_byte((i < nbody) ? body[i] : pick_byte());
  endtask

  // Mostly well-formed packets with random content, plus noise and broken framing.
  task automatic random_traffic(input int words);
    int stop_at;
    int pick;
    int kind;
    int esc_pct;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      esc_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 100);
      if (pick < 5) begin
        repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        if (pick < 11)       kind = PK_EMPTY;
        else if (pick < 19)  kind = PK_SHORT;
        else if (pick < 27)  kind = PK_BAD_SUM;
        else if (pick < 34)  kind = PK_PADDED;
        else if (pick == 34) kind = PK_MAXLEN;
        else                 kind = PK_GOOD;
        send_packet(kind, pick_byte(),
                    {pick_byte(), pick_byte(), pick_byte(), pick_byte()}, esc_pct);
      end
    end
  endtask

  // Receiver: pick a new stall pattern when the current one runs out. A hold-off request
  // from the stimulus overrides the pattern and is counted down here.
  initial begin : receiver
    int mode;
    int mode_left;
    out_ready = 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(RX_FREE, RX_PULSE);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_len > 0) begin
        hold_len--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 99) >= 30);
          RX_HEAVY: out_ready <= ($urandom_range(0, 99) >= 80);
          default:  out_ready <= (mode_left % 6 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0] tail_sum;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAD;
    cfg_data  = 8'd0;
    head_cur  = HEAD_RESET;
    esc_cur   = ESCAPE_RESET;
    mask_cur  = XOR_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets at the reset settings, no sender gaps.
    send_packet(PK_GOOD, 8'h00, 32'hFFFF_FFFF, 0);
    // head inside the body, forced escapes, and an escape escaping an escape value
    send_packet(PK_GOOD, head_cur, {esc_cur, esc_cur ^ mask_cur, head_cur, 8'h00}, 100);
    send_packet(PK_EMPTY, 8'h00, 32'd0, 0);
    send_packet(PK_BAD_SUM, 8'hFF, 32'h0000_0000, 0);

    // Change the escape value in the middle of a packet: head, length and
    // register word go out first, the data after the write.
    drain();
    push_byte(head_cur);
    push_byte(8'd7);
    push_byte(8'h3C);
    drain();
    write_reg(CFG_ESCAPE, 8'h11);
    cfg_valid <= 1'b0;
    tail_sum = 8'h3C + 8'h11 + (8'h22 ^ mask_cur) + 8'h01 + 8'h02 + 8'h03;
    push_byte(8'h11);
    push_byte(8'h22 ^ mask_cur);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    push_byte(tail_sum);

    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      case (phase_idx)
        0: configure(HEAD_RESET, ESCAPE_RESET, XOR_RESET);
        1: begin
          configure(8'h00, 8'hFF, 8'hFF);
          // unmapped index must leave the registers alone
          write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
          cfg_valid <= 1'b0;
        end
        2: configure(8'hFF, 8'h00, 8'h00);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      gap_max = (phase_idx % 3 == 0) ? 0 : $urandom_range(2, 12);
      random_traffic(WORDS_PER_PHASE);

      if (phase_idx == 1) begin
        // Hold the receiver off while short packets keep coming, so the output
        // buffer fills and in_ready drops; then pause until all results are out.
        hold_len = 300;
        gap_max  = 0;
        repeat (12) send_packet(PK_EMPTY, 8'h00, 32'd0, 0);
        repeat (3) send_packet(PK_GOOD, pick_byte(), $urandom, 30);
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("** escaped_packet_deframer: PASSED **");
    else
      $display("** escaped_packet_deframer: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("** escaped_packet_deframer: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/epd_pkg.sv
rtl/core/epd_out_buf.sv
rtl/core/escaped_packet_deframer.sv
tb/escaped_packet_deframer_checker.sv
tb/tb_escaped_packet_deframer.sv
